/* src/dsd_pkg.sv */
// ----------------------------------------------------------------------------
// dsd_pkg: dielectric scatter direction shared types and constants
// Word formats, pipeline stage plan and small arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dsd_pkg;

    localparam int FRAC = 14;
    localparam int ONE  = 1 << FRAC;

    localparam logic [14:0] IOR_MIN   = 15'd4096;
    localparam logic [14:0] IOR_MAX   = 15'd16384;
    localparam logic [14:0] IOR_RESET = 15'd6144;
    localparam logic [31:0] ETA_NUM   = 32'(1) << (FRAC + 12);

    localparam int ETA_STEPS = 15;
    localparam int R0_STEPS  = 14;
    localparam int INC_STEPS = 15;
    localparam int SQ32_STEPS = 16;
    localparam int SQ28_STEPS = 15;

    localparam int K_ETA  = 1;
    localparam int K_SQR  = 1;
    localparam int K_SUM  = K_SQR + 1;
    localparam int K_SQA  = K_SUM + 1;
    localparam int K_ETAF = K_ETA + ETA_STEPS;
    localparam int K_R0   = K_ETAF + 1;
    localparam int K_R0SQ = K_R0 + R0_STEPS;
    localparam int K_LEN  = K_SQA + SQ32_STEPS;
    localparam int K_INC  = K_LEN + 1;
    localparam int K_INCF = K_INC + INC_STEPS;
    localparam int K_DOT  = K_INCF + 1;
    localparam int K_DNI  = K_DOT + 1;
    localparam int K_COS  = K_DNI + 1;
    localparam int K_SQS  = K_COS + 1;
    localparam int K_X2   = K_COS + 1;
    localparam int K_X4   = K_X2 + 1;
    localparam int K_P    = K_X4 + 1;
    localparam int K_SQK  = K_X4 + 1;
    localparam int K_REFL = K_P + 1;
    localparam int K_TIR  = K_SQS + SQ28_STEPS;
    localparam int K_DEC  = K_TIR + 1;
    localparam int K_RDIR = K_DEC + 1;
    localparam int K_COEF = K_SQK + SQ32_STEPS;
    localparam int K_AB   = K_COEF + 1;
    localparam int K_OUT  = K_AB + 1;
    localparam int DEPTH  = K_OUT + 1;

    typedef struct packed {
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               hits_outside;
        logic [15:0]        random_draw;
    } t_in;

    typedef struct packed {
        logic signed [15:0] scatter_x;
        logic signed [15:0] scatter_y;
        logic signed [15:0] scatter_z;
        logic               was_reflected;
        logic               total_internal;
    } t_out;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] res;
    } t_sqrt;

    typedef struct packed {
        logic [31:0] rem;
        logic [15:0] q;
    } t_div;

    typedef struct packed {
        logic [2:0][15:0] v;
        logic [2:0][16:0] n;
        logic             outside;
        logic [15:0]      draw;
        logic [14:0]      ior;
        logic [2:0][30:0] vsq;
        t_sqrt            sa;
        t_sqrt            sb;
        t_div             e;
        t_div             r;
        t_div [2:0]       d;
        logic [16:0]      eta;
        logic [14:0]      r0sq;
        logic [15:0]      len;
        logic             len_zero;
        logic [2:0][15:0] inc;
        logic [2:0][32:0] prod;
        logic [18:0]      dni;
        logic [14:0]      x;
        logic [14:0]      x2;
        logic [14:0]      x4;
        logic [14:0]      p;
        logic [15:0]      refl;
        logic [21:0]      s2;
        logic [15:0]      t;
        logic             kneg;
        logic [20:0]      eta_dni;
        logic             tir;
        logic             reflect;
        logic [2:0][21:0] rdir;
        logic [20:0]      coef;
        logic [2:0][17:0] a;
        logic [2:0][21:0] b;
        logic [2:0][15:0] dir;
    } t_work;

    function automatic logic signed [47:0] fdiv(input logic signed [47:0] v);
        logic signed [47:0] s;
        s = v + ((v < 48'sd0) ? 48'(ONE - 1) : 48'sd0);
        return s >>> FRAC;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [47:0] v);
        logic [15:0] o;
        if (v > 48'sd32767) begin
            o = 16'h7fff;
        end else if (v < -48'sd32768) begin
            o = 16'h8000;
        end else begin
            o = v[15:0];
        end
        return o;
    endfunction

    function automatic logic [16:0] side_norm(input logic [15:0] nv, input logic outside);
        logic signed [16:0] e;
        e = 17'($signed(nv));
        return outside ? e : 17'(-e);
    endfunction

    function automatic t_sqrt sqrt_step(input t_sqrt s, input logic [31:0] sbit);
        t_sqrt       o;
        logic [32:0] tr;
        tr = {1'b0, s.res} + {1'b0, sbit};
        if ({1'b0, s.rem} >= tr) begin
            o.rem = s.rem - tr[31:0];
            o.res = (s.res >> 1) + sbit;
        end else begin
            o.rem = s.rem;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    function automatic t_div div_step(input t_div s, input logic [31:0] dsh,
                                      input logic [15:0] qb);
        t_div o;
        o = s;
        if (s.rem >= dsh) begin
            o.rem = s.rem - dsh;
            o.q   = s.q | qb;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

/* src/dielectric_scatter_direction.sv */
// ----------------------------------------------------------------------------
// dielectric_scatter_direction: glass reflect or refract choice per ray
// Normalises the incident ray, takes the Schlick decision and forms the
// reflected or refracted direction in Q2.14.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | word
//  in       | i_in_valid / o_in_ready    | i_in_data  (t_in)
//  out      | o_out_valid / i_out_ready  | o_out_data (t_out)
//  cfg      | i_cfg_wr_en                | i_cfg_wr_data (index of refraction)
//
//  Pipeline depth is set by the chained square roots and dividers.
//  While the output is not stalled, one word enters per cycle; throughput is one ray per clock.
//  A stalled output freezes every stage; bubbles travel as cleared valid bits.
//  Reset clears the valid bits and loads index 1.5; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dielectric_scatter_direction
    import dsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [14:0] i_cfg_wr_data
);

    logic [DEPTH-1:0] r_vld;
    t_work            r_st [DEPTH];
    t_work            n_st [DEPTH];
    logic [14:0]      r_ior;
    logic             w_adv;

    assign w_adv       = !r_vld[DEPTH-1] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vld[DEPTH-1];

    assign o_out_data.scatter_x      = r_st[DEPTH-1].dir[0];
    assign o_out_data.scatter_y      = r_st[DEPTH-1].dir[1];
    assign o_out_data.scatter_z      = r_st[DEPTH-1].dir[2];
    assign o_out_data.was_reflected  = r_st[DEPTH-1].reflect;
    assign o_out_data.total_internal = r_st[DEPTH-1].tir;

    always_comb begin
        t_work              w;
        logic signed [17:0] se;
        logic [15:0]        vabs;
        logic [16:0]        eta_c;
        logic [15:0]        rmag;
        logic [27:0]        sq28;
        logic [29:0]        u30;
        logic [31:0]        u32;
        logic signed [31:0] sq32;
        logic signed [32:0] p33;
        logic signed [33:0] m34;
        logic signed [34:0] dsum;
        logic signed [36:0] m37;
        logic signed [37:0] m38;
        logic signed [39:0] m40;
        logic signed [47:0] f48;
        logic signed [19:0] cosv;
        logic signed [19:0] xv;
        logic signed [15:0] cs;
        logic signed [17:0] kv;
        logic signed [21:0] s2t;
        int                 j;

        n_st[0]         = '0;
        n_st[0].v[0]    = i_in_data.view_x;
        n_st[0].v[1]    = i_in_data.view_y;
        n_st[0].v[2]    = i_in_data.view_z;
        n_st[0].n[0]    = side_norm(i_in_data.normal_x, i_in_data.hits_outside);
        n_st[0].n[1]    = side_norm(i_in_data.normal_y, i_in_data.hits_outside);
        n_st[0].n[2]    = side_norm(i_in_data.normal_z, i_in_data.hits_outside);
        n_st[0].outside = i_in_data.hits_outside;
        n_st[0].draw    = i_in_data.random_draw;
        n_st[0].ior     = (r_ior < IOR_MIN) ? IOR_MIN :
                          ((r_ior > IOR_MAX) ? IOR_MAX : r_ior);
        n_st[0].e.rem   = ETA_NUM;
        n_st[0].e.q     = '0;

        for (int k = 1; k < DEPTH; k++) begin
            w       = r_st[k-1];
            n_st[k] = w;
            se      = $signed({1'b0, w.eta});

            if (k == K_SQR) begin
                for (int i = 0; i < 3; i++) begin
                    sq32 = $signed(w.v[i]) * $signed(w.v[i]);
                    n_st[k].vsq[i] = sq32[30:0];
                end
            end
            if (k == K_SUM) begin
                n_st[k].sa.rem = 32'(w.vsq[0]) + 32'(w.vsq[1]) + 32'(w.vsq[2]);
                n_st[k].sa.res = '0;
            end
            if (k >= K_SQA && k < K_SQA + SQ32_STEPS) begin
                n_st[k].sa = sqrt_step(w.sa, 32'(1) << (30 - 2 * (k - K_SQA)));
            end

            if (k >= K_ETA && k < K_ETA + ETA_STEPS) begin
                j = ETA_STEPS - 1 - (k - K_ETA);
                n_st[k].e = div_step(w.e, 32'(w.ior) << j, 16'(1) << j);
            end
            if (k == K_ETAF) begin
                eta_c = w.outside ? {1'b0, w.e.q} : {w.ior, 2'b00};
                rmag  = (eta_c > 17'(ONE)) ? 16'(eta_c - 17'(ONE)) : 16'(17'(ONE) - eta_c);
                n_st[k].eta   = eta_c;
                n_st[k].r.rem = 32'(rmag) << FRAC;
                n_st[k].r.q   = '0;
                n_st[k].len   = '0;
            end
            if (k >= K_R0 && k < K_R0 + R0_STEPS) begin
                j = R0_STEPS - 1 - (k - K_R0);
                n_st[k].r = div_step(w.r, 32'(w.eta + 17'(ONE)) << j, 16'(1) << j);
            end
            if (k == K_R0SQ) begin
                sq28 = w.r.q[13:0] * w.r.q[13:0];
                n_st[k].r0sq = 15'(sq28 >> FRAC);
            end

            if (k == K_LEN) begin
                n_st[k].len      = w.sa.res[15:0];
                n_st[k].len_zero = (w.sa.res == '0);
                for (int i = 0; i < 3; i++) begin
                    vabs = w.v[i][15] ? 16'(-w.v[i]) : w.v[i];
                    n_st[k].d[i].rem = 32'(vabs) << FRAC;
                    n_st[k].d[i].q   = '0;
                end
            end
            if (k >= K_INC && k < K_INC + INC_STEPS) begin
                j = INC_STEPS - 1 - (k - K_INC);
                for (int i = 0; i < 3; i++) begin
                    n_st[k].d[i] = div_step(w.d[i], 32'(w.len) << j, 16'(1) << j);
                end
            end
            if (k == K_INCF) begin
                for (int i = 0; i < 3; i++) begin
                    if (w.len_zero) begin
                        n_st[k].inc[i] = '0;
                    end else if (!w.v[i][15]) begin
                        n_st[k].inc[i] = -w.d[i].q;
                    end else begin
                        n_st[k].inc[i] = w.d[i].q;
                    end
                end
            end
            if (k == K_DOT) begin
                for (int i = 0; i < 3; i++) begin
                    p33 = $signed(w.inc[i]) * $signed(w.n[i]);
                    n_st[k].prod[i] = p33;
                end
            end
            if (k == K_DNI) begin
                dsum = 35'($signed(w.prod[0])) + 35'($signed(w.prod[1]))
                     + 35'($signed(w.prod[2]));
                f48 = fdiv(48'(dsum));
                n_st[k].dni = f48[18:0];
            end
            if (k == K_COS) begin
                cosv = -(20'($signed(w.dni)));
                if (cosv > 20'(ONE)) begin
                    cosv = 20'(ONE);
                end
                n_st[k].sa.res = '0;
                cs = cosv[15:0];
                if (cosv <= -(20'(ONE))) begin
                    n_st[k].sa.rem = '0;
                end else begin
                    sq32 = cs * cs;
                    n_st[k].sa.rem = (32'(1) << (2 * FRAC)) - 32'(sq32);
                end
                xv = 20'(ONE) - cosv;
                n_st[k].x = (xv > 20'(ONE)) ? 15'(ONE) : xv[14:0];
                m38 = $signed(w.dni) * $signed(w.dni);
                s2t = 22'(ONE) - 22'(m38 >>> FRAC);
                n_st[k].s2 = s2t;
            end
            if (k >= K_SQS && k < K_SQS + SQ28_STEPS) begin
                n_st[k].sa = sqrt_step(w.sa, 32'(1) << (28 - 2 * (k - K_SQS)));
            end
            if (k == K_X2) begin
                u30 = 30'(w.x) * 30'(w.x);
                n_st[k].x2 = 15'(u30 >> FRAC);
                m40 = se * $signed(w.s2);
                f48 = fdiv(48'(m40));
                if (f48 > 48'(ONE)) begin
                    n_st[k].t = 16'(ONE);
                end else if (f48 < -(48'(ONE))) begin
                    n_st[k].t = 16'(-ONE);
                end else begin
                    n_st[k].t = f48[15:0];
                end
            end
            if (k == K_X4) begin
                u30 = 30'(w.x2) * 30'(w.x2);
                n_st[k].x4 = 15'(u30 >> FRAC);
                m34 = se * $signed(w.t);
                f48 = fdiv(48'(m34));
                kv  = 18'(ONE) - f48[17:0];
                n_st[k].kneg   = kv[17];
                n_st[k].sb.rem = kv[17] ? 32'd0 : (32'(kv) << FRAC);
                n_st[k].sb.res = '0;
                m37 = se * $signed(w.dni);
                f48 = fdiv(48'(m37));
                n_st[k].eta_dni = f48[20:0];
            end
            if (k == K_P) begin
                u30 = 30'(w.x4) * 30'(w.x);
                n_st[k].p = 15'(u30 >> FRAC);
            end
            if (k >= K_SQK && k < K_SQK + SQ32_STEPS) begin
                n_st[k].sb = sqrt_step(w.sb, 32'(1) << (30 - 2 * (k - K_SQK)));
            end
            if (k == K_REFL) begin
                u30 = 30'(15'(ONE) - w.r0sq) * 30'(w.p);
                n_st[k].refl = 16'(w.r0sq) + 16'(u30 >> FRAC);
            end
            if (k == K_TIR) begin
                u32 = 32'(w.eta) * 32'(w.sa.res[14:0]);
                n_st[k].tir = (u32 > (32'(1) << (2 * FRAC)));
            end
            if (k == K_DEC) begin
                n_st[k].reflect = w.tir || ({w.refl, 2'b00} > 18'(w.draw));
            end
            if (k == K_RDIR) begin
                for (int i = 0; i < 3; i++) begin
                    m38 = $signed(w.dni) * $signed(w.n[i]);
                    f48 = 48'($signed(w.inc[i])) - fdiv(48'(m38) <<< 1);
                    n_st[k].rdir[i] = f48[21:0];
                end
            end
            if (k == K_COEF) begin
                n_st[k].coef = w.eta_dni + 21'(w.sb.res[15:0]);
            end
            if (k == K_AB) begin
                for (int i = 0; i < 3; i++) begin
                    m34 = se * $signed(w.inc[i]);
                    f48 = fdiv(48'(m34));
                    n_st[k].a[i] = f48[17:0];
                    m38 = $signed(w.coef) * $signed(w.n[i]);
                    f48 = fdiv(48'(m38));
                    n_st[k].b[i] = f48[21:0];
                end
            end
            if (k == K_OUT) begin
                for (int i = 0; i < 3; i++) begin
                    if (w.reflect) begin
                        f48 = 48'($signed(w.rdir[i]));
                    end else if (w.kneg) begin
                        f48 = '0;
                    end else begin
                        f48 = 48'($signed(w.a[i])) - 48'($signed(w.b[i]));
                    end
                    n_st[k].dir[i] = sat16(f48);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ior <= IOR_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_ior <= i_cfg_wr_data;
            end
            if (w_adv) begin
                r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: dielectric scatter direction testbench
// Drives rays through the valid/ready input, predicts each scattered
// direction and its flags in fixed point, and checks them in order against
// the output. Sweeps the refractive index, including out-of-range values.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import dsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNIT  = 16384;
    localparam int     LIMIT = 400000;
    localparam int     DRAIN = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_wr_en;
    logic [14:0] i_cfg_wr_data;

    t_in         ray_pending[$];
    t_out        scatter_due[$];
    logic [14:0] ior_now;
    int          send_idle;
    int          recv_stall;
    int          errors;
    int          cycles;

    dielectric_scatter_direction DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) / UNIT;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_out scatter_ray(input t_in w, input logic [14:0] ior_reg);
        longint v[3], n[3], inc[3], dir[3];
        longint ior, eta, dni, cosv, sinv, r0, x, x2, x4, p, refl;
        longint s2, t, k, sk, coef;
        longint unsigned sum, len;
        logic   outside, tir, refl_hit;
        t_out   o;
        ior = clip(longint'(ior_reg), 4096, 16384);
        outside = w.hits_outside;
        v[0] = w.view_x; v[1] = w.view_y; v[2] = w.view_z;
        n[0] = w.normal_x; n[1] = w.normal_y; n[2] = w.normal_z;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (!outside) n[i] = -n[i];
            sum += longint'(v[i] * v[i]);
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++)
            inc[i] = (len == 0) ? 0 : (-v[i] * UNIT) / longint'(len);
        eta = outside ? (UNIT * 4096) / ior : (ior * UNIT) / 4096;
        dni = (inc[0] * n[0] + inc[1] * n[1] + inc[2] * n[2]) / UNIT;
        cosv = -dni;
        if (cosv > UNIT) cosv = UNIT;
        if (cosv <= -UNIT) sinv = 0;
        else sinv = floor_sqrt(UNIT * UNIT - cosv * cosv);
        tir = eta * sinv > UNIT * UNIT;
        r0 = ((UNIT - eta) * UNIT) / (UNIT + eta);
        r0 = qmul(r0, r0);
        x = UNIT - cosv;
        if (x > UNIT) x = UNIT;
        x2 = qmul(x, x);
        x4 = qmul(x2, x2);
        p = qmul(x4, x);
        refl = r0 + qmul(UNIT - r0, p);
        refl_hit = tir || (refl * 65536 > longint'(w.random_draw) * UNIT);
        if (refl_hit) begin
            for (int i = 0; i < 3; i++) dir[i] = inc[i] - (2 * dni * n[i]) / UNIT;
        end else begin
            s2 = UNIT - qmul(dni, dni);
            t = clip(qmul(eta, s2), -UNIT, UNIT);
            k = UNIT - qmul(eta, t);
            if (k < 0) begin
                dir[0] = 0; dir[1] = 0; dir[2] = 0;
            end else begin
                sk = floor_sqrt(k * UNIT);
                coef = qmul(eta, dni) + sk;
                for (int i = 0; i < 3; i++) dir[i] = qmul(eta, inc[i]) - qmul(coef, n[i]);
            end
        end
        o.scatter_x = 16'(clip(dir[0], -32768, 32767));
        o.scatter_y = 16'(clip(dir[1], -32768, 32767));
        o.scatter_z = 16'(clip(dir[2], -32768, 32767));
        o.was_reflected = refl_hit;
        o.total_internal = tir;
        return o;
    endfunction

    function automatic t_in make_ray(input logic signed [15:0] vx, input logic signed [15:0] vy,
                                     input logic signed [15:0] vz, input logic signed [15:0] nx,
                                     input logic signed [15:0] ny, input logic signed [15:0] nz,
                                     input logic hit_out, input logic [15:0] draw);
        t_in w;
        w.view_x = vx; w.view_y = vy; w.view_z = vz;
        w.normal_x = nx; w.normal_y = ny; w.normal_z = nz;
        w.hits_outside = hit_out;
        w.random_draw = draw;
        return w;
    endfunction

    function automatic t_in random_ray();
        t_in    w;
        longint c[3];
        longint len;
        w = '0;
        w.view_x = 16'($urandom);
        w.view_y = 16'($urandom);
        w.view_z = 16'($urandom);
        if ($urandom_range(9) == 0) begin
            w.view_x = 16'($signed($urandom_range(64)) - 32);
            w.view_y = 16'($signed($urandom_range(64)) - 32);
            w.view_z = 16'($signed($urandom_range(64)) - 32);
        end
        for (int i = 0; i < 3; i++) c[i] = longint'($urandom_range(32768)) - 16384;
        if ($urandom_range(4) != 0) begin
            len = floor_sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
            if (len == 0) begin
                c[0] = 0; c[1] = 0; c[2] = UNIT;
            end else begin
                for (int i = 0; i < 3; i++) c[i] = c[i] * UNIT / len;
            end
        end
        w.normal_x = 16'(c[0]);
        w.normal_y = 16'(c[1]);
        w.normal_z = 16'(c[2]);
        w.hits_outside = 1'($urandom_range(1));
        w.random_draw = 16'($urandom);
        return w;
    endfunction

    task automatic wait_idle();
        while (ray_pending.size() != 0 || i_in_valid || scatter_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_ior(input logic [14:0] val);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        ior_now       <= val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) scatter_due.push_back(scatter_ray(i_in_data, ior_now));
            if (!i_in_valid || o_in_ready) begin
                if (ray_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                    i_in_data  <= ray_pending.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(99) >= recv_stall;
            if (o_out_valid && i_out_ready) begin
                if (scatter_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word %h", o_out_data);
                end else begin
                    want = scatter_due.pop_front();
                    if (want !== o_out_data) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %0d %0d %0d r%0d t%0d got %0d %0d %0d r%0d t%0d",
                                     want.scatter_x, want.scatter_y, want.scatter_z,
                                     want.was_reflected, want.total_internal,
                                     o_out_data.scatter_x, o_out_data.scatter_y,
                                     o_out_data.scatter_z, o_out_data.was_reflected,
                                     o_out_data.total_internal);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [14:0] ior_plan[6];
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        ior_now       = IOR_RESET;
        send_idle     = 32;
        recv_stall    = 87;
        errors        = 0;
        cycles        = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        ray_pending.push_back(make_ray(0, 0, 0, 0, 0, 16384, 1, 0));
        ray_pending.push_back(make_ray(0, 0, 16384, 0, 0, 16384, 1, 0));
        ray_pending.push_back(make_ray(0, 0, 16384, 0, 0, 16384, 1, 16'hffff));
        ray_pending.push_back(make_ray(0, 0, 16384, 0, 0, 16384, 0, 16'hffff));
        ray_pending.push_back(make_ray(16384, 0, 100, 0, 0, 16384, 0, 16'hffff));
        ray_pending.push_back(make_ray(16384, 0, 8000, 0, 0, 16384, 0, 16'hffff));
        ray_pending.push_back(make_ray(16384, 0, 100, 0, 0, 16384, 1, 16'hffff));
        ray_pending.push_back(make_ray(32767, 32767, 32767, -16384, 0, 0, 1, 16'h8000));
        ray_pending.push_back(make_ray(-32768, -32768, -32768, 16384, 0, 0, 0, 16'h0001));
        ray_pending.push_back(make_ray(-32768, 0, 0, 0, -16384, 0, 1, 0));
        ray_pending.push_back(make_ray(0, 32767, 0, 0, 16384, 0, 0, 16'hffff));
        ray_pending.push_back(make_ray(0, 0, -16384, 0, 0, 16384, 1, 16'hffff));
        ray_pending.push_back(make_ray(1000, 2000, 3000, 16384, 16384, 16384, 1, 16'hffff));
        ray_pending.push_back(make_ray(1000, 2000, 3000, 16384, 16384, 16384, 0, 16'hffff));
        ray_pending.push_back(make_ray(5, -3, 1, 9000, -9000, 9000, 0, 16'h1234));
        ray_pending.push_back(make_ray(16384, 0, 1, 0, 0, -16384, 0, 16'hffff));

        ior_plan = '{15'd4096, 15'd16384, 15'd0, 15'd32767, 15'd6144, 15'd9000};
        ior_plan[5] = 15'($urandom_range(4096, 16384));
        for (int seg = 0; seg < 6; seg++) begin
            write_ior(ior_plan[seg]);
            send_idle  = (seg < 2) ? 32 : (seg < 4) ? 87 : 0;
            recv_stall = (seg < 2) ? 87 : (seg < 4) ? 32 : 0;
            for (int i = 0; i < 250; i++) ray_pending.push_back(random_ray());
        end
        wait_idle();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
